[hw/rtl/es2cd_pkg.sv]
`timescale 1ns / 1ps

package es2cd_pkg;

   localparam int unsigned EPOCH_W = 32;
   localparam int unsigned CSR_IDX_W = 2;

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_HOURS = 2'd1;

   localparam logic [EPOCH_W-1:0] EPOCH_BASE_RESET = 32'd946684800;
   localparam logic [EPOCH_W-1:0] SECS_PER_HOUR = 32'd3600;
   // Zone reset is +8 hours, kept here as seconds.
   localparam logic [EPOCH_W-1:0] ZONE_OFFSET_RESET = 32'd28800;

   localparam int unsigned PIPE_STAGES = 11;

   // Reciprocals for the constant divides. Each is exact over the value range it sees:
   // x / 60 = (x * RECIP_60) >> 37 for any 32-bit x, x / 24 = (x * RECIP_24) >> 36,
   // and x / 1461 = (x * RECIP_1461) >> 26 for any 16-bit x.
   localparam logic [31:0] RECIP_60 = 32'h8888_8889;
   localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
   localparam logic [15:0] RECIP_1461 = 16'd45934;
   localparam logic [15:0] DAYS_PER_BLOCK = 16'd1461;

   // First day of each month, counted from the start of a four-year block.
   localparam logic [10:0] BLOCK_DAYS [4][12] = '{
      '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
        11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
      '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
        11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
      '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
        11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
      '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
        11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
   };

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch_base;
      logic [EPOCH_W-1:0] zone_offset;
   } cfg_type;

   typedef struct packed {
      logic [7:0] year_since_2000;
      logic [3:0] month_number;
      logic [4:0] day_of_month;
      logic [4:0] hour_of_day;
      logic [5:0] minute_of_hour;
      logic [5:0] second_of_minute;
   } date_type;

endpackage

[hw/rtl/es2cd_if.sv]
`timescale 1ns / 1ps

interface es2cd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface es2cd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] year_since_2000;
   logic [3:0] month_number;
   logic [4:0] day_of_month;
   logic [4:0] hour_of_day;
   logic [5:0] minute_of_hour;
   logic [5:0] second_of_minute;

   modport source (output valid, output year_since_2000, output month_number,
                   output day_of_month, output hour_of_day, output minute_of_hour,
                   output second_of_minute, input ready);
   modport sink (input valid, input year_since_2000, input month_number,
                 input day_of_month, input hour_of_day, input minute_of_hour,
                 input second_of_minute, output ready);
endinterface

interface es2cd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/epoch_seconds_to_calendar_date_top.sv]
`timescale 1ns / 1ps

// Throughput: one beat per cycle while the response side takes beats; a stall at
// the output freezes the pipe of constant-reciprocal multiplies and the month table
// lookup, which holds up to 11 conversions in flight.
// Reset clears all valid bits and loads the epoch base and the +8 hour zone.
// Configuration writes are taken every cycle and apply to later request beats.
module epoch_seconds_to_calendar_date_top (
   input  logic         clock,
   input  logic         reset,
   es2cd_req_if.sink    req_chan,
   es2cd_rsp_if.source  rsp_chan,
   es2cd_csr_if.sink    csr_chan
);

   logic [31:0] base_ff, base_in;
   // The zone is kept as a signed seconds offset, worked out when written.
   logic [31:0] offset_ff, offset_in;
   logic [31:0] zone_ext;
   logic        advance;
   logic        pipe_valid;
   es2cd_pkg::cfg_type  cfg;
   es2cd_pkg::date_type pipe_date;

   always_comb begin
      zone_ext = {{27{csr_chan.data[4]}}, csr_chan.data[4:0]};
      base_in = base_ff;
      offset_in = offset_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            es2cd_pkg::CSR_EPOCH_BASE: base_in = csr_chan.data;
            es2cd_pkg::CSR_ZONE_HOURS: offset_in = zone_ext * es2cd_pkg::SECS_PER_HOUR;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= es2cd_pkg::EPOCH_BASE_RESET;
         offset_ff <= es2cd_pkg::ZONE_OFFSET_RESET;
      end else begin
         base_ff <= base_in;
         offset_ff <= offset_in;
      end
   end

   assign csr_chan.ready = 1'b1;
   assign cfg.epoch_base = base_ff;
   assign cfg.zone_offset = offset_ff;

   // The last stage is the output register; the pipe moves when it is free.
   assign advance = !pipe_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   es2cd_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .in_epoch  (req_chan.epoch_seconds),
      .cfg       (cfg),
      .out_valid (pipe_valid),
      .out_date  (pipe_date)
   );

   assign rsp_chan.valid = pipe_valid;
   assign rsp_chan.year_since_2000 = pipe_date.year_since_2000;
   assign rsp_chan.month_number = pipe_date.month_number;
   assign rsp_chan.day_of_month = pipe_date.day_of_month;
   assign rsp_chan.hour_of_day = pipe_date.hour_of_day;
   assign rsp_chan.minute_of_hour = pipe_date.minute_of_hour;
   assign rsp_chan.second_of_minute = pipe_date.second_of_minute;

endmodule

[hw/rtl/es2cd_pipe.sv]
`timescale 1ns / 1ps

module es2cd_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [31:0]            in_epoch,
   input  es2cd_pkg::cfg_type     cfg,
   output logic                   out_valid,
   output es2cd_pkg::date_type    out_date
);

   typedef struct packed {
      logic [4:0] hr;
      logic [5:0] min;
      logic [5:0] sec;
   } tod_type;

   logic [es2cd_pkg::PIPE_STAGES-1:0] vld_ff;

   // Stage 1: rebase and apply the zone, modulo 2^32.
   logic [31:0] e1_in, e1_ff;
   // Stage 2: multiply for the divide by 60.
   logic [31:0] e2_ff;
   logic [63:0] p2_in, p2_ff;
   // Stage 3: minutes total and seconds.
   logic [26:0] q3_in, q3_ff;
   logic [31:0] s3_full;
   logic [5:0]  sec3_in, sec3_ff;
   // Stage 4: multiply for the second divide by 60.
   logic [26:0] q4_ff;
   logic [57:0] p4_in, p4_ff;
   logic [5:0]  sec4_ff;
   // Stage 5: hours total and minutes.
   logic [20:0] q5_in, q5_ff;
   logic [26:0] m5_full;
   logic [5:0]  min5_in, min5_ff, sec5_ff;
   // Stage 6: multiply for the divide by 24.
   logic [20:0] q6_ff;
   logic [51:0] p6_in, p6_ff;
   logic [5:0]  min6_ff, sec6_ff;
   // Stage 7: day count and hour.
   logic [15:0] d7_in, d7_ff;
   logic [20:0] h7_full;
   tod_type     tod7_in, tod7_ff;
   // Stage 8: multiply for the divide by 1461.
   logic [15:0] d8_ff;
   logic [31:0] p8_in, p8_ff;
   tod_type     tod8_ff;
   // Stage 9: four-year block and day within it.
   logic [5:0]  blk9_in, blk9_ff;
   logic [15:0] r9_full;
   logic [10:0] rem9_in, rem9_ff;
   tod_type     tod9_ff;
   // Stage 10: year within the block.
   logic [5:0]  blk10_ff;
   logic [10:0] rem10_ff;
   logic [1:0]  yr10_in, yr10_ff;
   tod_type     tod10_ff;
   // Stage 11: month and day, output register.
   logic [3:0]  mo11;
   logic [10:0] dd11;
   es2cd_pkg::date_type out11_in, out11_ff;

   always_comb begin
      e1_in = in_epoch - cfg.epoch_base + cfg.zone_offset;

      p2_in = 64'(e1_ff) * 64'(es2cd_pkg::RECIP_60);

      q3_in = p2_ff[63:37];
      s3_full = e2_ff - 32'(q3_in) * 32'd60;
      sec3_in = s3_full[5:0];

      p4_in = 58'(q3_ff) * 58'(es2cd_pkg::RECIP_60);

      q5_in = p4_ff[57:37];
      m5_full = q4_ff - 27'(q5_in) * 27'd60;
      min5_in = m5_full[5:0];

      p6_in = 52'(q5_ff) * 52'(es2cd_pkg::RECIP_24);

      d7_in = p6_ff[51:36];
      h7_full = q6_ff - 21'(d7_in) * 21'd24;
      tod7_in.hr = h7_full[4:0];
      tod7_in.min = min6_ff;
      tod7_in.sec = sec6_ff;

      p8_in = 32'(d7_ff) * 32'(es2cd_pkg::RECIP_1461);

      blk9_in = p8_ff[31:26];
      r9_full = d8_ff - 16'(blk9_in) * es2cd_pkg::DAYS_PER_BLOCK;
      rem9_in = r9_full[10:0];

      if (rem9_ff >= es2cd_pkg::BLOCK_DAYS[3][0]) begin
         yr10_in = 2'd3;
      end else if (rem9_ff >= es2cd_pkg::BLOCK_DAYS[2][0]) begin
         yr10_in = 2'd2;
      end else if (rem9_ff >= es2cd_pkg::BLOCK_DAYS[1][0]) begin
         yr10_in = 2'd1;
      end else begin
         yr10_in = 2'd0;
      end

      // The month starts rise across the row, so the last one passed wins.
      mo11 = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (rem10_ff >= es2cd_pkg::BLOCK_DAYS[yr10_ff][m]) begin
            mo11 = 4'(m);
         end
      end
      dd11 = rem10_ff - es2cd_pkg::BLOCK_DAYS[yr10_ff][mo11] + 11'd1;

      out11_in.year_since_2000 = {blk10_ff, yr10_ff};
      out11_in.month_number = mo11 + 4'd1;
      out11_in.day_of_month = dd11[4:0];
      out11_in.hour_of_day = tod10_ff.hr;
      out11_in.minute_of_hour = tod10_ff.min;
      out11_in.second_of_minute = tod10_ff.sec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[es2cd_pkg::PIPE_STAGES-2:0], in_valid};
      end
   end

   // The whole pipe moves together; a stall freezes every stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         e1_ff <= e1_in;
         e2_ff <= e1_ff;
         p2_ff <= p2_in;
         q3_ff <= q3_in;
         sec3_ff <= sec3_in;
         q4_ff <= q3_ff;
         p4_ff <= p4_in;
         sec4_ff <= sec3_ff;
         q5_ff <= q5_in;
         min5_ff <= min5_in;
         sec5_ff <= sec4_ff;
         q6_ff <= q5_ff;
         p6_ff <= p6_in;
         min6_ff <= min5_ff;
         sec6_ff <= sec5_ff;
         d7_ff <= d7_in;
         tod7_ff <= tod7_in;
         d8_ff <= d7_ff;
         p8_ff <= p8_in;
         tod8_ff <= tod7_ff;
         blk9_ff <= blk9_in;
         rem9_ff <= rem9_in;
         tod9_ff <= tod8_ff;
         blk10_ff <= blk9_ff;
         rem10_ff <= rem9_ff;
         yr10_ff <= yr10_in;
         tod10_ff <= tod9_ff;
         out11_ff <= out11_in;
      end
   end

   assign out_valid = vld_ff[es2cd_pkg::PIPE_STAGES-1];
   assign out_date = out11_ff;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;
   localparam logic [31:0] SECS_HOUR = 32'd3600;
   localparam logic [31:0] SECS_DAY = 32'd86400;
   localparam int unsigned DAYS_QUAD = 1461;
   localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int unsigned PHASE_ITEMS = 100;

   logic clock;
   logic reset;

   es2cd_req_if req_bus ();
   es2cd_rsp_if rsp_bus ();
   es2cd_csr_if csr_bus ();

   epoch_seconds_to_calendar_date_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow copies of the two registers.
   logic [31:0] base_cfg;
   logic [4:0]  zone_cfg;

   logic [31:0]         pending_stamps [$];
   es2cd_pkg::date_type expected_dates [$];
   int unsigned error_count = 0;
   bit          idle_on = 1'b1;
   int unsigned gap_cnt = 0;
   int unsigned stall_cnt = 0;

   function automatic es2cd_pkg::date_type convert_epoch(logic [31:0] stamp);
      logic [31:0] shift;
      logic [31:0] secs;
      logic [31:0] days;
      int unsigned rem;
      int unsigned yr;
      int unsigned mo;
      int unsigned len;
      es2cd_pkg::date_type d;
      shift = {{27{zone_cfg[4]}}, zone_cfg} * SECS_HOUR;
      secs = stamp - base_cfg + shift;
      d.second_of_minute = 6'(secs % 60);
      d.minute_of_hour = 6'((secs / 60) % 60);
      d.hour_of_day = 5'((secs / SECS_HOUR) % 24);
      days = secs / SECS_DAY;
      rem = days % DAYS_QUAD;
      // The first year of every four-year block is a leap year, 2100 included.
      yr = 0;
      len = 366;
      while (rem >= len) begin
         rem -= len;
         yr++;
         len = 365;
      end
      mo = 0;
      len = MONTH_LEN[0];
      while (rem >= len) begin
         rem -= len;
         mo++;
         len = MONTH_LEN[mo] + ((mo == 1 && yr == 0) ? 1 : 0);
      end
      d.year_since_2000 = 8'((days / DAYS_QUAD) * 4 + yr);
      d.month_number = 4'(mo + 1);
      d.day_of_month = 5'(rem + 1);
      return d;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         es2cd_pkg::CSR_EPOCH_BASE: base_cfg = value;
         es2cd_pkg::CSR_ZONE_HOURS: zone_cfg = value[4:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_stamps.size() != 0 || req_bus.valid || expected_dates.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Request driver: presents queued timestamps, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.epoch_seconds <= '0;
         gap_cnt <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_dates.push_back(convert_epoch(req_bus.epoch_seconds));
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_cnt > 0) begin
               gap_cnt <= gap_cnt - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_stamps.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
               gap_cnt <= $urandom_range(0, 11);
               req_bus.valid <= 1'b0;
            end else if (pending_stamps.size() > 0) begin
               req_bus.valid <= 1'b1;
               req_bus.epoch_seconds <= pending_stamps.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each beat against the oldest prediction and stalls at random.
   always @(posedge clock) begin
      es2cd_pkg::date_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_cnt <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_dates.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               want = expected_dates.pop_front();
               check_field("year_since_2000", 32'(want.year_since_2000),
                           32'(rsp_bus.year_since_2000));
               check_field("month_number", 32'(want.month_number),
                           32'(rsp_bus.month_number));
               check_field("day_of_month", 32'(want.day_of_month),
                           32'(rsp_bus.day_of_month));
               check_field("hour_of_day", 32'(want.hour_of_day),
                           32'(rsp_bus.hour_of_day));
               check_field("minute_of_hour", 32'(want.minute_of_hour),
                           32'(rsp_bus.minute_of_hour));
               check_field("second_of_minute", 32'(want.second_of_minute),
                           32'(rsp_bus.second_of_minute));
            end
         end
         if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_cnt <= $urandom_range(0, 11);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] shift;
      logic [31:0] stamp;
      logic [4:0]  zone;
      logic [31:0] base;
      csr_bus.valid = 1'b0;
      csr_bus.index = es2cd_pkg::CSR_EPOCH_BASE;
      csr_bus.data = '0;
      base_cfg = es2cd_pkg::EPOCH_BASE_RESET;
      zone_cfg = 5'd8;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: range ends, the base itself, one second before it, and the base less the zone.
      pending_stamps.push_back(32'd0);
      pending_stamps.push_back(32'hFFFF_FFFF);
      pending_stamps.push_back(es2cd_pkg::EPOCH_BASE_RESET);
      pending_stamps.push_back(es2cd_pkg::EPOCH_BASE_RESET - 1);
      pending_stamps.push_back(es2cd_pkg::EPOCH_BASE_RESET - 32'd28800);
      drain();

      // Zero base and zone: the input is the offset from 2000-01-01 directly.
      write_csr(es2cd_pkg::CSR_EPOCH_BASE, 32'd0);
      write_csr(es2cd_pkg::CSR_ZONE_HOURS, 32'hFFFF_FFE0);
      pending_stamps.push_back(32'd59);
      pending_stamps.push_back(32'd60);
      pending_stamps.push_back(32'd3599);
      pending_stamps.push_back(32'd86399);
      pending_stamps.push_back(32'd86400);
      pending_stamps.push_back(32'd59 * SECS_DAY);           // Feb 29, 2000
      pending_stamps.push_back(32'd365 * SECS_DAY);          // Dec 31, 2000
      pending_stamps.push_back(32'd366 * SECS_DAY);
      pending_stamps.push_back(32'd1460 * SECS_DAY + 32'd86399);
      pending_stamps.push_back(32'd1461 * SECS_DAY);
      pending_stamps.push_back(32'd36584 * SECS_DAY);        // Feb 29, 2100
      pending_stamps.push_back(32'd36585 * SECS_DAY);
      pending_stamps.push_back(32'hFFFF_FFFF);
      drain();

      // Zone at both ends of its 5-bit range; writes to the spare indexes must be ignored.
      write_csr(es2cd_pkg::CSR_ZONE_HOURS, 32'd16);
      write_csr(CSR_SPARE_A, 32'hFFFF_FFFF);
      pending_stamps.push_back(32'd0);
      pending_stamps.push_back(32'd57600);
      drain();
      write_csr(es2cd_pkg::CSR_EPOCH_BASE, 32'hFFFF_FFFF);
      write_csr(es2cd_pkg::CSR_ZONE_HOURS, 32'd15);
      write_csr(CSR_SPARE_B, 32'h5555_5555);
      pending_stamps.push_back(32'd0);
      pending_stamps.push_back(32'hFFFF_FFFF);
      pending_stamps.push_back(32'hFFFF_FFFE);
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin base = 32'd0; zone = 5'b10100; end               // -12
            1: begin base = 32'hFFFF_FFFF; zone = 5'd14; end
            2: begin base = es2cd_pkg::EPOCH_BASE_RESET; zone = 5'd8; end
            default: begin base = $urandom; zone = 5'($urandom_range(0, 31)); end
         endcase
         write_csr(es2cd_pkg::CSR_EPOCH_BASE, base);
         write_csr(es2cd_pkg::CSR_ZONE_HOURS, {$urandom} << 5 | zone);
         if ($urandom_range(0, 1))
            write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, $urandom);
         idle_on = (p < 7) && (p != 4);
         shift = {{27{zone_cfg[4]}}, zone_cfg} * SECS_HOUR;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(0, 3))
               0, 1: stamp = $urandom;
               // Land on or next to a midnight.
               2: stamp = base_cfg - shift + $urandom_range(0, 49709) * SECS_DAY
                          + $urandom_range(0, 2) - 1;
               default: stamp = $urandom_range(0, 1) ? $urandom_range(0, 200)
                                                     : 32'hFFFF_FFFF - $urandom_range(0, 200);
            endcase
            pending_stamps.push_back(stamp);
         end
         drain();
      end

      repeat (30) @(posedge clock);
      if (error_count == 0 && expected_dates.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/es2cd_pkg.sv
hw/rtl/es2cd_if.sv
hw/rtl/es2cd_pipe.sv
hw/rtl/epoch_seconds_to_calendar_date_top.sv
sim/testbench.sv
